// ===== rtl/ss_pkg.sv =====
// ----------------------------------------------------------------------------
// ss_pkg
// Shared types and constants for the searchable stack core.
// ----------------------------------------------------------------------------
package ss_pkg;

  // Default number of stack entries
  localparam int unsigned SS_DEPTH = 16;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 3'd0,
    FN_SEARCH  = 3'd1,
    FN_MODIFY  = 3'd2,
    FN_DELETE  = 3'd3,
    FN_DISPLAY = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_DEL_RD,
    S_DEL_CHK,
    S_SHF_RD,
    S_SHF_WR,
    S_DSP_RD,
    S_DSP_OUT,
    S_RESP
  } state_e;

  // One result beat handed from the controller to the output register
  typedef struct packed {
    logic                     valid;
    status_e                  status;
    logic signed [WORD_W-1:0] entry_value;
    logic                     last;
  } rsp_beat_t;

endpackage

// ===== rtl/ss_if.sv =====
// ----------------------------------------------------------------------------
// ss_req_if / ss_rsp_if
// Valid/ready channels for operation requests and result beats.
// ----------------------------------------------------------------------------
interface ss_req_if import ss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] key_value;
  logic signed [WORD_W-1:0] new_value;

  modport source (output valid, output func, output key_value, output new_value,
                  input ready);
  modport sink   (input valid, input func, input key_value, input new_value,
                  output ready);
endinterface

interface ss_rsp_if import ss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] entry_value;
  logic                     last;

  modport source (output valid, output status, output entry_value, output last,
                  input ready);
  modport sink   (input valid, input status, input entry_value, input last,
                  output ready);
endinterface

// ===== rtl/searchable_stack_core.sv =====
// Push, unused codes and empty-stack results go from accept straight to the closing beat.
// Search and modify scan every stored entry from the bottom; delete scans down from the
// top to the match, then shifts each entry above it down by one; display reads each entry.
// One operation at a time; the next is accepted once its last beat is handed to the output
// register and the controller is back in idle. A scan step is a read state then a check state.
// Reset clears the entry count and the control state; entry storage is not cleared.
// ----------------------------------------------------------------------------
// searchable_stack_core
// Bounded LIFO stack with search, modify, delete and display operations.
// ----------------------------------------------------------------------------
module searchable_stack_core import ss_pkg::*; #(
  parameter int unsigned DEPTH = SS_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ss_req_if.sink   req_i,
  ss_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  rsp_beat_t                beat;
  logic                     rsp_free;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic signed [WORD_W-1:0] out_value_q;
  logic                     out_last_q;

  ss_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_func_i  (req_i.func),
    .req_key_i   (req_i.key_value),
    .req_new_i   (req_i.new_value),
    .rsp_free_i  (rsp_free),
    .rsp_beat_o  (beat),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  ss_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // output register: free when empty or its beat leaves this cycle
  assign rsp_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_free) begin
      out_valid_q <= beat.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_free && beat.valid) begin
      out_status_q <= beat.status;
      out_value_q  <= beat.entry_value;
      out_last_q   <= beat.last;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_value = out_value_q;
  assign rsp_o.last        = out_last_q;

endmodule

// ===== rtl/ss_mem.sv =====
// ----------------------------------------------------------------------------
// ss_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ss_mem import ss_pkg::*; #(
  parameter int unsigned DEPTH = SS_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic signed [WORD_W-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic signed [WORD_W-1:0] rd_data_o
);

  logic signed [WORD_W-1:0] mem_q [DEPTH];
  logic signed [WORD_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/ss_ctrl.sv =====
// ----------------------------------------------------------------------------
// ss_ctrl
// Operation sequencer: entry count, scan index and memory read/modify/write.
// ----------------------------------------------------------------------------
module ss_ctrl import ss_pkg::*; #(
  parameter int unsigned DEPTH = SS_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request side
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic [FUNC_W-1:0]        req_func_i,
  input  logic signed [WORD_W-1:0] req_key_i,
  input  logic signed [WORD_W-1:0] req_new_i,
  // result side
  input  logic                     rsp_free_i,
  output rsp_beat_t                rsp_beat_o,
  // memory port
  output logic                     wr_en_o,
  output logic [AW-1:0]            wr_addr_o,
  output logic signed [WORD_W-1:0] wr_data_o,
  output logic                     rd_en_o,
  output logic [AW-1:0]            rd_addr_o,
  input  logic signed [WORD_W-1:0] rd_data_i
);

  state_e                   state_q, state_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     hit_q, hit_d;
  status_e                  status_q, status_d;
  logic [FUNC_W-1:0]        func_q, func_d;
  logic signed [WORD_W-1:0] key_q, key_d;
  logic signed [WORD_W-1:0] new_q, new_d;

  logic [CW-1:0] top_idx;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_p1;
  logic          match;
  logic          at_top;
  logic          accept;

  assign top_idx = count_q - CW'(1);
  assign idx_m1  = idx_q - CW'(1);
  assign idx_p1  = idx_q + CW'(1);
  assign match   = (rd_data_i == key_q);
  assign at_top  = (idx_q == top_idx);
  assign accept  = req_valid_i && req_ready_o;

  // state and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    func_q   <= func_d;
    key_q    <= key_d;
    new_q    <= new_d;
  end

  // next state, memory accesses and result beats
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    hit_d      = hit_q;
    status_d   = status_q;
    func_d     = func_q;
    key_d      = key_q;
    new_d      = new_q;
    req_ready_o = 1'b0;
    wr_en_o    = 1'b0;
    wr_addr_o  = idx_q[AW-1:0];
    wr_data_o  = new_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = idx_q[AW-1:0];
    rsp_beat_o = '{valid: 1'b0, status: ST_DONE, entry_value: '0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (accept) begin
          func_d   = req_func_i;
          key_d    = req_key_i;
          new_d    = req_new_i;
          hit_d    = 1'b0;
          status_d = ST_DONE;
          state_d  = S_RESP;
          case (func_e'(req_func_i))
            FN_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = count_q[AW-1:0];
                wr_data_o = req_key_i;
                count_d   = count_q + CW'(1);
              end
            end
            FN_SEARCH, FN_MODIFY: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_SRCH_RD;
              end
            end
            FN_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                idx_d   = top_idx;
                state_d = S_DEL_RD;
              end
            end
            FN_DISPLAY: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                idx_d   = top_idx;
                state_d = S_DSP_RD;
              end
            end
            default: begin
              status_d = ST_DONE;
            end
          endcase
        end
      end

      // bottom-up scan for search and modify
      S_SRCH_RD: begin
        rd_en_o = 1'b1;
        state_d = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        hit_d = hit_q | match;
        if (match && (func_e'(func_q) == FN_MODIFY)) begin
          wr_en_o = 1'b1;
        end
        if (at_top) begin
          if (hit_q | match) begin
            status_d = (func_e'(func_q) == FN_MODIFY) ? ST_DONE : ST_FOUND;
          end else begin
            status_d = ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end else begin
          idx_d   = idx_p1;
          state_d = S_SRCH_RD;
        end
      end

      // top-down scan for the delete target
      S_DEL_RD: begin
        rd_en_o = 1'b1;
        state_d = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (match) begin
          if (at_top) begin
            count_d  = top_idx;
            status_d = ST_DONE;
            state_d  = S_RESP;
          end else begin
            idx_d   = idx_p1;
            state_d = S_SHF_RD;
          end
        end else if (idx_q == '0) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          idx_d   = idx_m1;
          state_d = S_DEL_RD;
        end
      end

      // close the gap: entry idx moves to idx-1
      S_SHF_RD: begin
        rd_en_o = 1'b1;
        state_d = S_SHF_WR;
      end
      S_SHF_WR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_m1[AW-1:0];
        wr_data_o = rd_data_i;
        if (at_top) begin
          count_d  = top_idx;
          status_d = ST_DONE;
          state_d  = S_RESP;
        end else begin
          idx_d   = idx_p1;
          state_d = S_SHF_RD;
        end
      end

      // display, top to bottom, one beat per entry
      S_DSP_RD: begin
        rd_en_o = 1'b1;
        state_d = S_DSP_OUT;
      end
      S_DSP_OUT: begin
        if (rsp_free_i) begin
          rsp_beat_o = '{valid: 1'b1, status: ST_DONE, entry_value: rd_data_i,
                         last: (idx_q == '0)};
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_m1;
            state_d = S_DSP_RD;
          end
        end
      end

      // single closing beat
      S_RESP: begin
        if (rsp_free_i) begin
          rsp_beat_o = '{valid: 1'b1, status: status_q, entry_value: '0, last: 1'b1};
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
